@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL. Synthesis builds define SYNTH so that
// every use collapses to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The condition c must hold in the same cycle as a.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// The condition c must hold in the cycle after a.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif

`endif

@@ sv/mdat_pkg.sv @@
`default_nettype none

package mdat_pkg;

    // Table size and the highest mesh address that may be handed out.
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_LIMIT  = 255;

    // Lowest mesh address the free search considers.
    localparam logic [15:0] FIRST_ADDR = 16'h0002;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SLOT_W = 4;

    // Only TABLE_DEPTH addresses can be taken, so a free one always lies
    // within the first TABLE_DEPTH + 1 candidates.
    localparam int FREE_N = TABLE_DEPTH + 1;

    // Code seven has no meaning; the block answers it with zeros.
    typedef enum logic [2:0] {
        ACT_MAC_BY_MESH = 3'd0,
        ACT_MESH_BY_MAC = 3'd1,
        ACT_ADD         = 3'd2,
        ACT_DELETE      = 3'd3,
        ACT_DEACTIVATE  = 3'd4,
        ACT_FIND_FREE   = 3'd5,
        ACT_SET_ACTIVE  = 3'd6,
        ACT_UNUSED      = 3'd7
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [15:0] mesh;
        logic [47:0] mac;
        logic        active;
        logic [6:0]  dev_type;
    } entry_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] mesh_addr;
        logic [47:0] mac_addr;
        logic [6:0]  dev_type;
        logic        new_active;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot_index;
        logic [15:0]       found_mesh_addr;
        logic [47:0]       found_mac;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/mdat_ram.sv @@
`default_nettype none

// Single-port-write, single-port-read RAM with a registered read.
module mdat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/mesh_device_address_table.sv @@
`default_nettype none

// Channel   Ports                 Handshake
// request   req (req_t)           taken at a clock edge with start high, busy low
// result    rsp (rsp_t)           valid for the one cycle that done is high
//
// An unused action code or a mesh lookup above the address limit answers in the
// next cycle. Every other action reads one slot per cycle from the entry RAM:
// lookups, add, delete and set activation stop at the first hit or after the
// last slot; deactivate-all and find-free sweep all slots.
// The result shows in the cycle right after the last busy cycle, which may take a
// new word. Reset clears the valid flags at once; the receiver cannot stall results.

`include "assert_macros.svh"

module mesh_device_address_table
    import mdat_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp
);

    localparam int EW = $bits(entry_t);

    // The table lives in one RAM; a slot whose valid flag is clear reads as
    // an all-zero entry, which is exactly the state after reset or delete.
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    req_t                   req_reg, req_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [FREE_N-1:0]      used_reg, used_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   done_reg, done_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    logic [EW-1:0]    ram_rdata;

    entry_t cur;
    logic   accept;
    logic   last;
    logic   immediate;
    logic   hit;
    logic   finish;

    mdat_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign last   = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign cur    = valid_reg[idx_reg] ? entry_t'(ram_rdata) : '0;

    // Words that never need the table.
    always_comb
    begin
        immediate = 1'b0;
        if (req.action == ACT_UNUSED)
        begin
            immediate = 1'b1;
        end
        else if ((req.action == ACT_MAC_BY_MESH) && (req.mesh_addr > 16'(ADDR_LIMIT)))
        begin
            immediate = 1'b1;
        end
    end

    // Slot compare for the actions that stop at the first match.
    always_comb
    begin
        hit = 1'b0;
        case (req_reg.action)
            ACT_MAC_BY_MESH, ACT_SET_ACTIVE: hit = (cur.mesh == req_reg.mesh_addr);
            ACT_MESH_BY_MAC, ACT_DELETE:     hit = (cur.mac == req_reg.mac_addr);
            ACT_ADD:                         hit = (cur.mesh == 16'd0);
            default:                         hit = 1'b0;
        endcase
    end

    assign finish = (state_reg == ST_SCAN) && (hit || last);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && !immediate)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        idx_next   = idx_reg;
        req_next   = req_reg;
        valid_next = valid_reg;
        used_next  = used_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_wdata  = cur;
        ram_raddr  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Slot zero is read now so its data is ready in the first
                // scan cycle.
                ram_raddr = '0;
                if (accept)
                begin
                    req_next  = req;
                    idx_next  = '0;
                    used_next = '0;
                    if (immediate)
                    begin
                        rsp_next  = '0;
                        done_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_raddr = last ? '0 : (idx_reg + IDX_W'(1));
                idx_next  = idx_reg + IDX_W'(1);
                if (finish)
                begin
                    rsp_next  = '0;
                    done_next = 1'b1;
                end

                case (req_reg.action)
                    ACT_MAC_BY_MESH:
                    begin
                        if (hit)
                        begin
                            rsp_next.ok        = 1'b1;
                            rsp_next.found_mac = cur.mac;
                        end
                    end
                    ACT_MESH_BY_MAC:
                    begin
                        if (hit)
                        begin
                            rsp_next.ok              = 1'b1;
                            rsp_next.found_mesh_addr = cur.mesh;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (hit)
                        begin
                            ram_we             = 1'b1;
                            ram_wdata.mesh     = req_reg.mesh_addr;
                            ram_wdata.mac      = req_reg.mac_addr;
                            ram_wdata.active   = 1'b1;
                            ram_wdata.dev_type = req_reg.dev_type;
                            valid_next[idx_reg] = 1'b1;
                            rsp_next.ok         = 1'b1;
                            rsp_next.slot_index = SLOT_W'(idx_reg);
                        end
                    end
                    ACT_DELETE:
                    begin
                        // Dropping the valid flag makes the slot read as zero.
                        if (hit)
                        begin
                            valid_next[idx_reg] = 1'b0;
                            rsp_next.ok         = 1'b1;
                        end
                    end
                    ACT_SET_ACTIVE:
                    begin
                        if (hit)
                        begin
                            ram_we              = 1'b1;
                            ram_wdata.active    = req_reg.new_active;
                            valid_next[idx_reg] = 1'b1;
                            rsp_next.ok         = 1'b1;
                        end
                    end
                    ACT_DEACTIVATE:
                    begin
                        // Write back each live slot with its active bit cleared
                        // while the next slot is being read.
                        ram_we           = valid_reg[idx_reg];
                        ram_wdata.active = 1'b0;
                        if (last)
                        begin
                            rsp_next.ok = 1'b1;
                        end
                    end
                    ACT_FIND_FREE:
                    begin
                        // Bit j marks candidate FIRST_ADDR + j as taken.
                        for (int j = 0; j < FREE_N; j++)
                        begin
                            if (cur.mesh == (FIRST_ADDR + 16'(j)))
                            begin
                                used_next[j] = 1'b1;
                            end
                        end
                        if (last)
                        begin
                            for (int j = FREE_N - 1; j >= 0; j--)
                            begin
                                if (!used_next[j] && ((FIRST_ADDR + 16'(j)) <= 16'(ADDR_LIMIT)))
                                begin
                                    rsp_next.ok              = 1'b1;
                                    rsp_next.found_mesh_addr = FIRST_ADDR + 16'(j);
                                end
                            end
                        end
                    end
                    default:
                    begin
                        rsp_next = '0;
                    end
                endcase
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        used_reg <= used_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // The table is only ever written during a scan.
    `ASSERT_SAME(a_write_in_scan, clk, rst_n, ram_we, state_reg == ST_SCAN)
    // A result is never shown while a scan is still running.
    `ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    // A word that needs the table starts a scan in the next cycle.
    `ASSERT_NEXT(a_scan_starts, clk, rst_n, accept && !immediate, state_reg == ST_SCAN)
    // The scan never runs past the last slot.
    `ASSERT_NEXT(a_scan_ends, clk, rst_n, (state_reg == ST_SCAN) && last,
                 (state_reg == ST_IDLE) && done_reg)
    // Only a successful add reports a nonzero slot.
    `ASSERT_SAME(a_slot_ok, clk, rst_n, done_reg && (rsp_reg.slot_index != '0), rsp_reg.ok)

endmodule

`default_nettype wire
